/* design/mvt_pkg.sv */
// shared types and constants of the 4x4 matrix by vector transform
package mvt_pkg;

	localparam int NUM_REGS   = 8;
	localparam int NUM_LANES  = 4;
	localparam int REG_W      = 64;
	localparam int COEF_W     = 32;
	localparam int ADDR_W     = 6;
	localparam int PROD_W     = 64;
	localparam int PAIR_W     = 65;
	localparam int SUM_W      = 66;

	// identity matrix after reset
	localparam logic [REG_W-1:0] CFG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000,
		64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000
	};

	localparam logic signed [SUM_W-1:0] ROUND_HALF = 66'sh8000;
	localparam logic [COEF_W-1:0] SAT_POS = 32'h7fff_ffff;
	localparam logic [COEF_W-1:0] SAT_NEG = 32'h8000_0000;

	// load enables of the pipeline stages
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} mvt_pipe_ctrl_t;

endpackage

/* design/mvt_lane.sv */
// one output component: four products, adder tree, rounding and saturation
module mvt_lane (
	input  logic                                clk,
	input  mvt_pkg::mvt_pipe_ctrl_t             ctrl,
	input  logic signed [mvt_pkg::COEF_W-1:0]   coef [mvt_pkg::NUM_LANES],
	input  logic signed [mvt_pkg::COEF_W-1:0]   vec [mvt_pkg::NUM_LANES],
	output logic        [mvt_pkg::COEF_W-1:0]   res,
	output logic                                sat
);

	logic signed [mvt_pkg::PROD_W-1:0] prod_s1 [mvt_pkg::NUM_LANES];
	logic signed [mvt_pkg::PAIR_W-1:0] pair_s2 [2];
	logic signed [mvt_pkg::SUM_W-1:0]  sum_s3;
	logic signed [mvt_pkg::SUM_W-1:0]  rnd;
	logic                              in_range;
	logic        [mvt_pkg::COEF_W-1:0] res_d;
	logic        [mvt_pkg::COEF_W-1:0] res_s4;
	logic                              sat_s4;

	// stage 1: one product per input component
	always_ff @(posedge clk) begin
		if (ctrl.en1) begin
			for (int i = 0; i < mvt_pkg::NUM_LANES; i++) begin
				prod_s1[i] <= mvt_pkg::PROD_W'(coef[i]) * mvt_pkg::PROD_W'(vec[i]);
			end
		end
	end

	// stage 2: pair sums
	always_ff @(posedge clk) begin
		if (ctrl.en2) begin
			pair_s2[0] <= mvt_pkg::PAIR_W'(prod_s1[0]) + mvt_pkg::PAIR_W'(prod_s1[1]);
			pair_s2[1] <= mvt_pkg::PAIR_W'(prod_s1[2]) + mvt_pkg::PAIR_W'(prod_s1[3]);
		end
	end

	// stage 3: exact total
	always_ff @(posedge clk) begin
		if (ctrl.en3) begin
			sum_s3 <= mvt_pkg::SUM_W'(pair_s2[0]) + mvt_pkg::SUM_W'(pair_s2[1]);
		end
	end

	// round half up, then clip to signed 32 bits
	always_comb begin
		rnd      = sum_s3 + mvt_pkg::ROUND_HALF;
		in_range = (&rnd[mvt_pkg::SUM_W-1:47]) | ~(|rnd[mvt_pkg::SUM_W-1:47]);
		if (in_range) begin
			res_d = rnd[47:16];
		end else if (rnd[mvt_pkg::SUM_W-1]) begin
			res_d = mvt_pkg::SAT_NEG;
		end else begin
			res_d = mvt_pkg::SAT_POS;
		end
	end

	// stage 4: result register
	always_ff @(posedge clk) begin
		if (ctrl.en4) begin
			res_s4 <= res_d;
			sat_s4 <= ~in_range;
		end
	end

	assign res = res_s4;
	assign sat = sat_s4;

endmodule

/* design/mvt_ctrl.sv */
// valid tracking and stall handling of the four stage pipeline
module mvt_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	output mvt_pkg::mvt_pipe_ctrl_t ctrl
);

	logic v1_q, v2_q, v3_q, v4_q;
	logic rdy1, rdy2, rdy3, rdy4;

	// a stage takes new data when it is empty or its content moves on
	always_comb begin
		rdy4 = ~v4_q | ~out_stall;
		rdy3 = ~v3_q | rdy4;
		rdy2 = ~v2_q | rdy3;
		rdy1 = ~v1_q | rdy2;
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
		end else begin
			if (rdy1) v1_q <= in_valid;
			if (rdy2) v2_q <= v1_q;
			if (rdy3) v3_q <= v2_q;
			if (rdy4) v4_q <= v3_q;
		end
	end

	// data loads only where valid data arrives
	assign ctrl.en1 = rdy1 & in_valid;
	assign ctrl.en2 = rdy2 & v1_q;
	assign ctrl.en3 = rdy3 & v2_q;
	assign ctrl.en4 = rdy4 & v3_q;

	assign in_stall  = ~rdy1;
	assign out_valid = v4_q;

endmodule

/* design/mat4_vec4_transform.sv */
// 4x4 matrix by 4-vector transform, signed Q16.16, four output lanes
//
//  channel   signals                                         moves
//  input     in_valid, in_stall, vec_x..vec_w                one vector per transfer
//  output    out_valid, out_stall, out_x..out_w, saturated   one vector per transfer
//  config    psel, penable, pwrite, paddr, pwdata ...        8 x 64-bit matrix registers
//
// one vector enters per cycle while in_stall is low, since every stage of each
// lane is fully pipelined; four register stages (multiply, two adder levels,
// round and saturate) lie between an input transfer and its result on the output.
// reset loads the identity matrix and empties the pipeline.
// a stall on the output holds the last stage; earlier stages keep moving
// into empty slots, so input is stalled only when the pipeline is full.
module mat4_vec4_transform (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [mvt_pkg::COEF_W-1:0]     vec_x,
	input  logic signed [mvt_pkg::COEF_W-1:0]     vec_y,
	input  logic signed [mvt_pkg::COEF_W-1:0]     vec_z,
	input  logic signed [mvt_pkg::COEF_W-1:0]     vec_w,
	// output channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [mvt_pkg::COEF_W-1:0]     out_x,
	output logic signed [mvt_pkg::COEF_W-1:0]     out_y,
	output logic signed [mvt_pkg::COEF_W-1:0]     out_z,
	output logic signed [mvt_pkg::COEF_W-1:0]     out_w,
	output logic                                  saturated,
	// register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic        [mvt_pkg::ADDR_W-1:0]     paddr,
	input  logic        [mvt_pkg::REG_W-1:0]      pwdata,
	output logic        [mvt_pkg::REG_W-1:0]      prdata,
	output logic                                  pready
);

	logic [mvt_pkg::REG_W-1:0]          cfg_q [mvt_pkg::NUM_REGS];
	logic [2:0]                         reg_idx;
	logic signed [mvt_pkg::COEF_W-1:0]  vec [mvt_pkg::NUM_LANES];
	logic [mvt_pkg::COEF_W-1:0]         lane_res [mvt_pkg::NUM_LANES];
	logic [mvt_pkg::NUM_LANES-1:0]      lane_sat;
	mvt_pkg::mvt_pipe_ctrl_t            ctrl;

	// register file, one 64-bit register every 8 bytes
	assign reg_idx = paddr[5:3];
	assign pready  = 1'b1;
	assign prdata  = cfg_q[reg_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < mvt_pkg::NUM_REGS; r++) begin
				cfg_q[r] <= mvt_pkg::CFG_RESET[r];
			end
		end else if (psel && penable && pwrite && pready) begin
			cfg_q[reg_idx] <= pwdata;
		end
	end

	// pipeline control
	mvt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctrl      (ctrl)
	);

	assign vec[0] = vec_x;
	assign vec[1] = vec_y;
	assign vec[2] = vec_z;
	assign vec[3] = vec_w;

	// one lane per output component
	for (genvar j = 0; j < mvt_pkg::NUM_LANES; j++) begin : g_lane
		logic signed [mvt_pkg::COEF_W-1:0] coef [mvt_pkg::NUM_LANES];

		// weight of input i for output j
		for (genvar i = 0; i < mvt_pkg::NUM_LANES; i++) begin : g_coef
			assign coef[i] = cfg_q[2*i + j/2][mvt_pkg::COEF_W*(j%2) +: mvt_pkg::COEF_W];
		end

		mvt_lane u_lane (
			.clk  (clk),
			.ctrl (ctrl),
			.coef (coef),
			.vec  (vec),
			.res  (lane_res[j]),
			.sat  (lane_sat[j])
		);
	end

	// merge lane results
	assign out_x     = lane_res[0];
	assign out_y     = lane_res[1];
	assign out_z     = lane_res[2];
	assign out_w     = lane_res[3];
	assign saturated = |lane_sat;

endmodule
